>>> rtl/core/number_to_led_matrix_digits_unit_macros.svh
// Assertion macros shared by the digit renderer.
`ifndef NUMBER_TO_LED_MATRIX_DIGITS_UNIT_MACROS_SVH
`define NUMBER_TO_LED_MATRIX_DIGITS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define NLMD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

`define NLMD_ASSERT_ON(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("%m: invariant check failed");

`else

`define NLMD_ASSERT_IMP(lbl, ante, cons)

`define NLMD_ASSERT_ON(lbl, cond)

`endif

`endif

>>> rtl/core/nlmd_pkg.sv
package nlmd_pkg;

    localparam int VALUE_W   = 24;
    localparam int MODE_W    = 3;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = 6;
    localparam int ROW_W     = 12;
    localparam int ROWS      = 8;
    localparam int GLYPH_H   = 5;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = ROW_W * ROWS;

    localparam logic [VALUE_W-1:0] DIV10_MUL   = 24'd13421773;
    localparam int                 DIV10_SHIFT = 27;

    localparam logic [VALUE_W-1:0] LIM_1E3 = 24'd1000;
    localparam logic [VALUE_W-1:0] LIM_1E4 = 24'd10000;
    localparam logic [VALUE_W-1:0] LIM_1E5 = 24'd100000;
    localparam logic [VALUE_W-1:0] LIM_1E6 = 24'd1000000;

    localparam logic [MODE_W-1:0] MODE_FIX0 = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIX1 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIX2 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIX3 = 3'd3;

    localparam logic [1:0] DOT_POS0 = 2'd0;
    localparam logic [1:0] DOT_POS1 = 2'd1;
    localparam logic [1:0] DOT_POS2 = 2'd2;
    localparam logic [1:0] DOT_NONE = 2'd3;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [ROW_W-1:0]   UNDERLINE = 12'h00E;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [3*GLYPH_H-1:0] t_glyph;

    typedef struct packed {
        logic [VALUE_W-1:0]           q;
        logic [DIGITS-1:0][DIGIT_W-1:0] dig;
        logic [1:0]                   p;
        logic                         ovf;
    } t_stage;

    // Row r of the glyph sits in bits 3r+2..3r, bit 0 being the leftmost column.
    function automatic t_glyph glyph(input t_digit d);
        t_glyph g;
        unique case (d)
            4'd0: g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1: g = {3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
            4'd2: g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            4'd3: g = {3'd7, 3'd4, 3'd7, 3'd4, 3'd7};
            4'd4: g = {3'd4, 3'd4, 3'd7, 3'd5, 3'd5};
            4'd5: g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd6: g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
            4'd7: g = {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
            4'd8: g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9: g = {3'd4, 3'd4, 3'd7, 3'd5, 3'd7};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/core/number_to_led_matrix_digits_unit.sv
// Channel  Dir  Width  Contents
// s_axis   in   32     value_thousandths[23:0], decimal_mode[26:24]
// m_axis   out  96     row_0 .. row_7, twelve bits each, row_0 lowest
//
// One word enters per cycle unless m_axis_tready stalls a full pipeline.
// Six stages each divide by ten with a reciprocal multiplier and peel off one digit.
// Each stage has its own valid bit and ready, so stalls close up bubbles.
// Reset clears only the valid bits.
`include "number_to_led_matrix_digits_unit_macros.svh"

module number_to_led_matrix_digits_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // value_thousandths, decimal_mode, zero padding
    input  logic [nlmd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // row_0, row_1, row_2, row_3, row_4, row_5, row_6, row_7
    output logic [nlmd_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import nlmd_pkg::*;

    localparam int NSTG = DIGITS + 1;

    logic [NSTG:0]              r_vld;
    logic [NSTG:0]              w_rdy;
    t_stage                     r_st [NSTG];
    t_stage                     n_st [NSTG];
    logic [2*VALUE_W-1:0]       w_prod [1:NSTG-1];
    logic [M_TDATA_W-1:0]       r_rows;
    logic [M_TDATA_W-1:0]       n_rows;

    logic [VALUE_W-1:0]         w_val;
    logic [MODE_W-1:0]          w_mode;
    logic                       w_auto;
    logic [1:0]                 w_p;
    t_digit                     w_d1;
    t_digit                     w_d2;
    t_digit                     w_d3;
    t_glyph                     w_g1;
    t_glyph                     w_g2;
    t_glyph                     w_g3;

    always_comb begin
        w_rdy[NSTG] = !r_vld[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_val  = s_axis_tdata[VALUE_W-1:0];
    assign w_mode = s_axis_tdata[VALUE_W +: MODE_W];
    assign w_auto = w_mode > MODE_FIX3;

    always_comb begin
        priority if ((w_auto && w_val >= LIM_1E5) || w_mode == MODE_FIX0) begin
            w_p = DOT_NONE;
        end else if ((w_auto && w_val >= LIM_1E4) || w_mode == MODE_FIX1) begin
            w_p = DOT_POS2;
        end else if ((w_auto && w_val >= LIM_1E3) || w_mode == MODE_FIX2) begin
            w_p = DOT_POS1;
        end else begin
            w_p = DOT_POS0;
        end
    end

    always_comb begin
        n_st[0].q   = w_val;
        n_st[0].dig = '0;
        n_st[0].p   = w_p;
        unique case (w_p)
            DOT_POS0: n_st[0].ovf = w_val >= LIM_1E3;
            DOT_POS1: n_st[0].ovf = w_val >= LIM_1E4;
            DOT_POS2: n_st[0].ovf = w_val >= LIM_1E5;
            DOT_NONE: n_st[0].ovf = w_val >= LIM_1E6;
            default:  n_st[0].ovf = 1'b0;
        endcase
        for (int k = 1; k < NSTG; k++) begin
            n_st[k]   = r_st[k-1];
            w_prod[k] = (2*VALUE_W)'(r_st[k-1].q) * (2*VALUE_W)'(DIV10_MUL);
            n_st[k].q = VALUE_W'(w_prod[k] >> DIV10_SHIFT);
            n_st[k].dig[k-1] = r_st[k-1].q[DIGIT_W-1:0]
                             - ({n_st[k].q[0], 3'b000} + {n_st[k].q[2:0], 1'b0});
        end
    end

    always_comb begin
        unique case (r_st[NSTG-1].p)
            DOT_POS0: begin
                w_d3 = r_st[NSTG-1].dig[0];
                w_d2 = r_st[NSTG-1].dig[1];
                w_d1 = r_st[NSTG-1].dig[2];
            end
            DOT_POS1: begin
                w_d3 = r_st[NSTG-1].dig[1];
                w_d2 = r_st[NSTG-1].dig[2];
                w_d1 = r_st[NSTG-1].dig[3];
            end
            DOT_POS2: begin
                w_d3 = r_st[NSTG-1].dig[2];
                w_d2 = r_st[NSTG-1].dig[3];
                w_d1 = r_st[NSTG-1].dig[4];
            end
            default: begin
                w_d3 = r_st[NSTG-1].dig[3];
                w_d2 = r_st[NSTG-1].dig[4];
                w_d1 = r_st[NSTG-1].dig[5];
            end
        endcase
    end

    always_comb begin
        w_g3 = glyph(w_d3);
        if (w_d1 == '0 && r_st[NSTG-1].p != DOT_POS0) begin
            w_g1 = '0;
        end else begin
            w_g1 = glyph(w_d1);
        end
        if (w_d2 == '0 && w_d1 == '0
            && (r_st[NSTG-1].p == DOT_POS2 || r_st[NSTG-1].p == DOT_NONE)) begin
            w_g2 = '0;
        end else begin
            w_g2 = glyph(w_d2);
        end
    end

    always_comb begin
        n_rows[0 +: ROW_W] = '0;
        for (int r = 0; r < GLYPH_H; r++) begin
            n_rows[(r+1)*ROW_W +: ROW_W] = {w_g3[3*r +: 3], 1'b0, w_g2[3*r +: 3], 1'b0,
                                            w_g1[3*r +: 3], 1'b0};
        end
        unique case (r_st[NSTG-1].p)
            DOT_POS0: n_rows[6*ROW_W +: ROW_W] = 12'h001;
            DOT_POS1: n_rows[6*ROW_W +: ROW_W] = 12'h010;
            DOT_POS2: n_rows[6*ROW_W +: ROW_W] = 12'h100;
            default:  n_rows[6*ROW_W +: ROW_W] = '0;
        endcase
        n_rows[7*ROW_W +: ROW_W] = r_st[NSTG-1].ovf ? UNDERLINE : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k <= NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && s_axis_tvalid) begin
            r_st[0] <= n_st[0];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_rdy[k] && r_vld[k-1]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (w_rdy[NSTG] && r_vld[NSTG-1]) begin
            r_rows <= n_rows;
        end
    end

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tdata  = r_rows;

    `NLMD_ASSERT_IMP(a_digit_range, r_vld[NSTG-1],
        r_st[NSTG-1].dig[0] <= DIGIT_MAX && r_st[NSTG-1].dig[1] <= DIGIT_MAX
        && r_st[NSTG-1].dig[2] <= DIGIT_MAX && r_st[NSTG-1].dig[3] <= DIGIT_MAX
        && r_st[NSTG-1].dig[4] <= DIGIT_MAX && r_st[NSTG-1].dig[5] <= DIGIT_MAX)
    `NLMD_ASSERT_IMP(a_ovf_matches_quotient, r_vld[NSTG-1] && r_st[NSTG-1].p == DOT_NONE,
        r_st[NSTG-1].ovf == (r_st[NSTG-1].q != '0))
    `NLMD_ASSERT_IMP(a_full_stall_blocks_input, (&r_vld) && !m_axis_tready, !s_axis_tready)
    `NLMD_ASSERT_ON(a_frame_shape, !m_axis_tvalid
        || ($onehot0(m_axis_tdata[6*ROW_W +: ROW_W]) && m_axis_tdata[ROW_W-1:0] == '0))

endmodule

>>> dv/number_to_led_matrix_digits_unit_test.sv
`timescale 1ns / 100ps

module number_to_led_matrix_digits_unit_test;

    import nlmd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_AUTO    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNUSED5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED7 = 3'd7;

    localparam int RANDOM_WORDS = 1230;
    localparam int SETTLE_CYCLES = 16;

    typedef logic [ROWS-1:0][ROW_W-1:0] t_frame;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [MODE_W-1:0]  mode;
        bit                 drain_first;
    } t_number_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // value_thousandths, decimal_mode, zero padding
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // row_0, row_1, row_2, row_3, row_4, row_5, row_6, row_7
    logic [M_TDATA_W-1:0] m_axis_tdata;

    t_number_req pending_numbers[$];
    t_frame      frames_due[$];

    logic word_taken = 1'b0;
    int   words_in = 0;
    int   frames_checked = 0;
    int   error_count = 0;
    int   underline_frames = 0;
    int   dotless_frames = 0;
    int   auto_frames = 0;

    int burst_left = 0;
    int idle_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int stall_seg = 0;
    int stall_kind = 0;

    number_to_led_matrix_digits_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Rows 1 to 5 of a digit, top row in the highest bits; bit 0 of a row is the left column.
    function automatic logic [14:0] segment_pattern(input logic [3:0] digit);
        case (digit)
            4'd0: return {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1: return {3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
            4'd2: return {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd3: return {3'd7, 3'd4, 3'd7, 3'd4, 3'd7};
            4'd4: return {3'd5, 3'd5, 3'd7, 3'd4, 3'd4};
            4'd5: return {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            4'd6: return {3'd7, 3'd1, 3'd7, 3'd5, 3'd7};
            4'd7: return {3'd7, 3'd4, 3'd4, 3'd4, 3'd4};
            4'd8: return {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9: return {3'd7, 3'd5, 3'd7, 3'd4, 3'd4};
            default: return '0;
        endcase
    endfunction

    function automatic t_frame draw_digit(input t_frame frame, input logic [3:0] digit,
                                          input int col);
        logic [14:0] pattern;
        int r;
        pattern = segment_pattern(digit);
        for (r = 0; r < 5; r++) begin
            frame[r + 1] = frame[r + 1] | (ROW_W'(pattern[14 - 3 * r -: 3]) << (col + 1));
        end
        return frame;
    endfunction

    function automatic t_frame render_frame(input logic [VALUE_W-1:0] value,
                                            input logic [MODE_W-1:0] mode);
        t_frame             frame;
        logic [1:0]         dot;
        logic [VALUE_W-1:0] shown;
        logic [3:0]         d1;
        logic [3:0]         d2;
        logic [3:0]         d3;
        logic               auto_places;
        auto_places = mode > MODE_FIX3;
        if ((auto_places && value >= LIM_1E5) || mode == MODE_FIX0) begin
            dot = DOT_NONE;
        end else if ((auto_places && value >= LIM_1E4) || mode == MODE_FIX1) begin
            dot = DOT_POS2;
        end else if ((auto_places && value >= LIM_1E3) || mode == MODE_FIX2) begin
            dot = DOT_POS1;
        end else begin
            dot = DOT_POS0;
        end
        case (dot)
            DOT_NONE: shown = VALUE_W'(value / 1000);
            DOT_POS2: shown = VALUE_W'(value / 100);
            DOT_POS1: shown = VALUE_W'(value / 10);
            default:  shown = value;
        endcase
        d3 = 4'(shown % 10);
        d2 = 4'((shown / 10) % 10);
        d1 = 4'((shown / 100) % 10);
        frame = '0;
        if (shown >= 1000) begin
            frame[7] = UNDERLINE;
        end
        if (d1 != 0 || dot == DOT_POS0) begin
            frame = draw_digit(frame, d1, 0);
        end
        if (d2 != 0 || d1 != 0 || dot == DOT_POS0 || dot == DOT_POS1) begin
            frame = draw_digit(frame, d2, 4);
        end
        frame = draw_digit(frame, d3, 8);
        if (dot != DOT_NONE) begin
            frame[6][4 * dot] = 1'b1;
        end
        return frame;
    endfunction

    task automatic queue_number(input logic [VALUE_W-1:0] value, input logic [MODE_W-1:0] mode,
                                input bit drain_first);
        t_number_req req;
        req.value = value;
        req.mode = mode;
        req.drain_first = drain_first;
        pending_numbers.push_back(req);
    endtask

    always @(negedge i_clk) begin
        logic                 next_valid;
        logic [S_TDATA_W-1:0] next_data;
        t_number_req          req;
        next_valid = s_axis_tvalid;
        next_data = s_axis_tdata;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            next_valid = 1'b0;
            if (idle_left > 0 && hold_left == 0) begin
                idle_left--;
            end else if (pending_numbers.size() > 0 &&
                         !(pending_numbers[0].drain_first && frames_due.size() != 0)) begin
                req = pending_numbers.pop_front();
                next_valid = 1'b1;
                next_data = '0;
                next_data[VALUE_W-1:0] = req.value;
                next_data[VALUE_W +: MODE_W] = req.mode;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata <= next_data;
    end

    always @(negedge i_clk) begin
        logic next_ready;
        if (!i_rst_n) begin
            next_ready = 1'b0;
        end else if (hold_left > 0) begin
            next_ready = 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && words_in >= 300 + 500 * holds_done) begin
            next_ready = 1'b0;
            hold_left <= 150;
            holds_done <= holds_done + 1;
        end else begin
            if (stall_seg == 0) begin
                stall_kind = $urandom_range(0, 3);
                stall_seg = $urandom_range(8, 60);
            end
            stall_seg--;
            case (stall_kind)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                2: next_ready = ($urandom_range(0, 3) == 0);
                default: next_ready = stall_seg[1];
            endcase
        end
        m_axis_tready <= next_ready;
    end

    always @(posedge i_clk) begin
        t_frame want;
        t_frame got;
        int     r;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                want = render_frame(s_axis_tdata[VALUE_W-1:0], s_axis_tdata[VALUE_W +: MODE_W]);
                frames_due.push_back(want);
                words_in <= words_in + 1;
                if (want[7] != '0) underline_frames++;
                if (want[6] == '0) dotless_frames++;
                if (s_axis_tdata[VALUE_W +: MODE_W] > MODE_FIX3) auto_frames++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (frames_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected frame, actual %024h", $time, got);
                end else begin
                    want = frames_due.pop_front();
                    for (r = 0; r < ROWS; r++) begin
                        if (got[r] !== want[r]) begin
                            error_count++;
                            $display("%0t: frame %0d row %0d expected %03h actual %03h",
                                     $time, frames_checked, r, want[r], got[r]);
                        end
                    end
                end
                frames_checked++;
            end
        end
    end

    initial begin
        int                 n;
        int                 k;
        logic [VALUE_W-1:0] v;
        logic [MODE_W-1:0]  m;
        int                 edges[5];
        edges = '{1000, 10000, 100000, 1000000, 10000000};

        queue_number(24'd0, MODE_FIX0, 1'b0);
        queue_number(24'd0, MODE_FIX3, 1'b0);
        queue_number(24'd0, MODE_AUTO, 1'b0);
        queue_number(24'hFFFFFF, MODE_FIX0, 1'b0);
        queue_number(24'hFFFFFF, MODE_FIX3, 1'b0);
        queue_number(24'hFFFFFF, MODE_AUTO, 1'b0);
        queue_number(24'd999, MODE_AUTO, 1'b0);
        queue_number(24'd1000, MODE_AUTO, 1'b0);
        queue_number(24'd9999, MODE_AUTO, 1'b0);
        queue_number(24'd10000, MODE_AUTO, 1'b0);
        queue_number(24'd99999, MODE_AUTO, 1'b0);
        queue_number(24'd100000, MODE_AUTO, 1'b0);
        queue_number(24'd5, MODE_UNUSED5, 1'b0);
        queue_number(24'd12345, MODE_UNUSED6, 1'b0);
        queue_number(24'd987654, MODE_UNUSED7, 1'b0);
        queue_number(24'd1000000, MODE_FIX0, 1'b0);
        queue_number(24'd9999999, MODE_FIX1, 1'b0);
        queue_number(24'd7, MODE_FIX2, 1'b0);
        queue_number(24'd40, MODE_FIX1, 1'b0);
        queue_number(24'd123, MODE_FIX3, 1'b0);
        queue_number(24'd8080, MODE_FIX2, 1'b0);
        queue_number(24'd2468, MODE_FIX1, 1'b0);
        queue_number(24'd13579, MODE_FIX0, 1'b0);
        queue_number(24'hAAAAAA, MODE_FIX2, 1'b0);
        queue_number(24'h555555, MODE_FIX1, 1'b0);

        for (n = 0; n < RANDOM_WORDS; n++) begin
            k = $urandom_range(0, 5);
            case (k)
                0: v = VALUE_W'($urandom_range(0, 1099));
                1: v = VALUE_W'($urandom_range(0, 11000));
                2: v = VALUE_W'($urandom_range(0, 110000));
                3: v = VALUE_W'($urandom_range(0, 1100000));
                4: v = VALUE_W'($urandom & 32'hFFFFFF);
                default: v = VALUE_W'(edges[$urandom_range(0, 4)] + $urandom_range(0, 6) - 3);
            endcase
            if ($urandom_range(0, 9) < 7) begin
                m = MODE_W'($urandom_range(0, 4));
            end else begin
                m = MODE_W'($urandom_range(0, 7));
            end
            queue_number(v, m, n == 0 || n % 250 == 249);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (frames_due.size() != 0) begin
            error_count++;
            $display("%0t: %0d frames never arrived", $time, frames_due.size());
        end
        $display("Rendered %0d numbers into %0d checked frames, %0d in automatic places mode.",
                 words_in, frames_checked, auto_frames);
        $display("Of these, %0d lit the overflow underline and %0d had no decimal dot.",
                 underline_frames, dotless_frames);
        if (error_count == 0) begin
            $display("[number_to_led_matrix_digits_unit] OK");
        end else begin
            $display("[number_to_led_matrix_digits_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d frames outstanding.", frames_due.size());
        $display("[number_to_led_matrix_digits_unit] ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/nlmd_pkg.sv
rtl/core/number_to_led_matrix_digits_unit.sv
dv/number_to_led_matrix_digits_unit_test.sv
